// File: rtl/kei_pkg.sv
// ----------------------------------------------------------------------------
// kei_pkg
// Shared types, field positions and helpers for the keyframe envelope
// interpolator.
// ----------------------------------------------------------------------------
package kei_pkg;

  // Register file layout
  localparam int SLOTS      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int TIMING_W   = 49;
  localparam int COLOUR_W   = 64;
  localparam int IDX_W      = 2;

  // Field positions inside a timing word
  localparam int DUR_LSB = 0;
  localparam int TRN_LSB = 16;
  localparam int WID_LSB = 32;
  localparam int EN_BIT  = 48;

  // Value lanes
  localparam int VAL_W      = 16;
  localparam int NUM_VALS   = 5;
  localparam int LANE_WIDTH = 0;
  localparam int LANE_RED   = 1;
  localparam int LANE_GREEN = 2;
  localparam int LANE_BLUE  = 3;
  localparam int LANE_ALPHA = 4;

  // Fraction divider: 17 quotient bits, a few per stage
  localparam int FRAC_W        = 17;
  localparam int DIV_STEPS     = 17;
  localparam int DIV_PER_STAGE = 4;
  localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  // Product of a signed lane difference and an unsigned fraction
  localparam int PROD_W = (VAL_W + 1) + (FRAC_W + 1);

  typedef logic [NUM_VALS-1:0][VAL_W-1:0] kei_vals_t;

  // Which keyframe answers the request and how
  typedef struct packed {
    logic             empty;
    logic             past;
    logic             interp;
    logic [IDX_W-1:0] idx;
  } kei_sel_t;

  // Walk pipeline state
  typedef struct packed {
    logic             done;
    kei_sel_t         sel;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] tr;
  } kei_wstate_t;

  // Divider pipeline state
  typedef struct packed {
    kei_sel_t          sel;
    logic [VAL_W-1:0]  rem;
    logic [VAL_W-1:0]  dvsr;
    logic [FRAC_W-1:0] quo;
  } kei_dstate_t;

  // Selection plus blend fraction
  typedef struct packed {
    kei_sel_t          sel;
    logic [FRAC_W-1:0] frac;
  } kei_frac_t;

  // Unpack one keyframe into its five value lanes
  function automatic kei_vals_t kei_vals(input logic [TIMING_W-1:0] timing,
                                         input logic [COLOUR_W-1:0] colour);
    kei_vals_t v;
    v = '0;
    v[LANE_WIDTH] = timing[WID_LSB +: VAL_W];
    for (int c = 0; c < 4; c++) begin
      v[LANE_RED + c] = colour[c*VAL_W +: VAL_W];
    end
    return v;
  endfunction

endpackage

// File: rtl/keyframe_envelope_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_envelope_interpolator
// Maps a point's age to a ribbon width and RGBA colour from a keyframe table.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request: an age in Q4.12 seconds.
//   out_valid/out_ready return one result per request, in order: width Q8.8
//   and red, green, blue, alpha in Q1.15.
//   cfg_we/cfg_index/cfg_wdata write the keyframe table; index 2k is the
//   timing word of keyframe k, 2k+1 its colour. Write only while idle.
// Throughput: one request per cycle while the result side keeps up.
// Pipeline: one walk stage per keyframe, five divider stages that resolve
//   four quotient bits each (one in the last, 17 in all), one multiply
//   stage and the output register.
// Reset: clears the table (no keyframe enabled) and every pipeline valid bit.
// Stall: while out_valid is high and out_ready low, the whole pipeline holds,
//   in_ready drops and nothing in flight is lost or repeated.
// ----------------------------------------------------------------------------
module keyframe_envelope_interpolator #(
  parameter int KEYFRAMES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [kei_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kei_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [kei_pkg::VAL_W-1:0]      in_age,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [kei_pkg::VAL_W-1:0]      out_ribbon_width,
  output logic [kei_pkg::VAL_W-1:0]      out_red,
  output logic [kei_pkg::VAL_W-1:0]      out_green,
  output logic [kei_pkg::VAL_W-1:0]      out_blue,
  output logic [kei_pkg::VAL_W-1:0]      out_alpha
);
  import kei_pkg::*;

  // Keyframe table; only the slots the walk can reach are stored
  logic [TIMING_W-1:0] key_timing_r [KEYFRAMES];
  logic [COLOUR_W-1:0] key_colour_r [KEYFRAMES];

  logic        en;
  logic        walk_valid;
  kei_wstate_t walk_state;
  logic        div_valid;
  kei_frac_t   div_frac;
  kei_vals_t   vals;

  // Advance every stage whenever the output register is free or drains
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Decode the write: even index hits timing, odd hits colour; drop writes
  // to slots beyond the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KEYFRAMES; k++) begin
        key_timing_r[k] <= '0;
        key_colour_r[k] <= '0;
      end
    end else if (cfg_we) begin
      for (int k = 0; k < KEYFRAMES; k++) begin
        if (cfg_index[CFG_IDX_W-1:1] == (CFG_IDX_W-1)'(k)) begin
          if (cfg_index[0]) begin
            key_colour_r[k] <= cfg_wdata[COLOUR_W-1:0];
          end else begin
            key_timing_r[k] <= cfg_wdata[TIMING_W-1:0];
          end
        end
      end
    end
  end

  // Walk the keyframes: empty table, hold, transition or past the end
  kei_walk #(
    .KEYFRAMES (KEYFRAMES)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_age     (in_age),
    .key_timing (key_timing_r),
    .out_valid  (walk_valid),
    .out_state  (walk_state)
  );

  // Fraction of the transition elapsed, Q1.16
  kei_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (walk_valid),
    .in_state  (walk_state),
    .out_valid (div_valid),
    .out_frac  (div_frac)
  );

  // Blend the five lanes and register the result
  kei_blend #(
    .KEYFRAMES (KEYFRAMES)
  ) u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (div_valid),
    .in_frac    (div_frac),
    .key_timing (key_timing_r),
    .key_colour (key_colour_r),
    .out_valid  (out_valid),
    .out_vals   (vals)
  );

  assign out_ribbon_width = vals[LANE_WIDTH];
  assign out_red          = vals[LANE_RED];
  assign out_green        = vals[LANE_GREEN];
  assign out_blue         = vals[LANE_BLUE];
  assign out_alpha        = vals[LANE_ALPHA];

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// File: rtl/kei_walk.sv
// ----------------------------------------------------------------------------
// kei_walk
// Keyframe walk, one register stage per keyframe.
// ----------------------------------------------------------------------------
module kei_walk #(
  parameter int KEYFRAMES = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [kei_pkg::VAL_W-1:0]    in_age,
  input  logic [kei_pkg::TIMING_W-1:0] key_timing [KEYFRAMES],
  output logic                         out_valid,
  output kei_pkg::kei_wstate_t         out_state
);
  import kei_pkg::*;

  logic [KEYFRAMES-1:0] key_on;
  logic [KEYFRAMES-1:0] key_last;
  logic [KEYFRAMES:0]   on_ext;
  logic                 vld_r [KEYFRAMES];
  kei_wstate_t          st_r  [KEYFRAMES];

  always_comb begin
    for (int k = 0; k < KEYFRAMES; k++) begin
      key_on[k] = key_timing[k][EN_BIT];
    end
  end

  // A keyframe is the last counted one when the next is off or absent
  assign on_ext   = {1'b0, key_on};
  assign key_last = key_on & ~on_ext[KEYFRAMES:1];

  for (genvar k = 0; k < KEYFRAMES; k++) begin : g_stage
    kei_wstate_t      cur_st;
    kei_wstate_t      st_nxt;
    logic             vld_in;
    logic [VAL_W-1:0] dur;
    logic [VAL_W-1:0] trn;
    logic [VAL_W-1:0] a_rem;

    assign dur = key_timing[k][DUR_LSB +: VAL_W];
    assign trn = key_timing[k][TRN_LSB +: VAL_W];

    if (k == 0) begin : g_head
      always_comb begin
        cur_st      = '0;
        cur_st.a    = in_age;
      end
      assign vld_in = in_valid;
    end else begin : g_body
      assign cur_st = st_r[k-1];
      assign vld_in = vld_r[k-1];
    end

    always_comb begin
      a_rem  = cur_st.a - dur;
      st_nxt = cur_st;
      if (!cur_st.done) begin
        if (!key_on[k]) begin
          st_nxt.done      = 1'b1;
          st_nxt.sel.empty = 1'b1;
        end else if (cur_st.a <= dur || key_last[k]) begin
          st_nxt.done     = 1'b1;
          st_nxt.sel.idx  = IDX_W'(k);
          st_nxt.sel.past = cur_st.a > dur;
        end else if (trn != '0 && a_rem <= trn) begin
          st_nxt.done       = 1'b1;
          st_nxt.sel.idx    = IDX_W'(k);
          st_nxt.sel.interp = 1'b1;
          st_nxt.a          = a_rem;
          st_nxt.tr         = trn;
        end else begin
          st_nxt.a = a_rem - trn;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  assign out_valid = vld_r[KEYFRAMES-1];
  assign out_state = st_r[KEYFRAMES-1];

  // every request has found its keyframe by the end of the walk
  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[KEYFRAMES-1] |-> st_r[KEYFRAMES-1].done)
    else $error("walk left a request unresolved");

endmodule

// File: rtl/kei_div.sv
// ----------------------------------------------------------------------------
// kei_div
// Pipelined restoring divider for the blend fraction a * 2^16 / transition.
// ----------------------------------------------------------------------------
module kei_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  kei_pkg::kei_wstate_t in_state,
  output logic                 out_valid,
  output kei_pkg::kei_frac_t   out_frac
);
  import kei_pkg::*;

  logic        vld_r [DIV_STAGES];
  kei_dstate_t st_r  [DIV_STAGES];
  kei_dstate_t head_st;

  always_comb begin
    head_st      = '0;
    head_st.sel  = in_state.sel;
    head_st.rem  = in_state.a;
    head_st.dvsr = in_state.tr;
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    kei_dstate_t cur_st;
    kei_dstate_t st_nxt;
    logic        vld_in;

    if (g == 0) begin : g_head
      assign cur_st = head_st;
      assign vld_in = in_valid;
    end else begin : g_body
      assign cur_st = st_r[g-1];
      assign vld_in = vld_r[g-1];
    end

    // first step compares the remainder as is, later steps shift it first
    always_comb begin
      logic [VAL_W:0] trial;
      logic           qbit;
      st_nxt = cur_st;
      trial  = '0;
      qbit   = 1'b0;
      for (int j = 0; j < DIV_PER_STAGE; j++) begin
        if (g*DIV_PER_STAGE + j < DIV_STEPS) begin
          if (g*DIV_PER_STAGE + j == 0) begin
            trial = {1'b0, st_nxt.rem};
          end else begin
            trial = {st_nxt.rem, 1'b0};
          end
          if (trial >= {1'b0, st_nxt.dvsr}) begin
            trial = trial - {1'b0, st_nxt.dvsr};
            qbit  = 1'b1;
          end else begin
            qbit  = 1'b0;
          end
          st_nxt.rem = trial[VAL_W-1:0];
          st_nxt.quo = {st_nxt.quo[FRAC_W-2:0], qbit};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g] <= st_nxt;
      end
    end
  end

  assign out_valid     = vld_r[DIV_STAGES-1];
  assign out_frac.sel  = st_r[DIV_STAGES-1].sel;
  assign out_frac.frac = st_r[DIV_STAGES-1].sel.interp ? st_r[DIV_STAGES-1].quo : '0;

  // fraction never exceeds one
  a_frac_max: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[DIV_STAGES-1] && st_r[DIV_STAGES-1].sel.interp)
      |-> (st_r[DIV_STAGES-1].quo <= FRAC_W'(1 << VAL_W)))
    else $error("blend fraction above one");

  // restoring division keeps the remainder below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[DIV_STAGES-1] && st_r[DIV_STAGES-1].sel.interp)
      |-> (st_r[DIV_STAGES-1].rem < st_r[DIV_STAGES-1].dvsr))
    else $error("divider remainder out of range");

endmodule

// File: rtl/kei_blend.sv
// ----------------------------------------------------------------------------
// kei_blend
// Lane blend: multiply stage, then sum into the output register.
// ----------------------------------------------------------------------------
module kei_blend #(
  parameter int KEYFRAMES = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  kei_pkg::kei_frac_t           in_frac,
  input  logic [kei_pkg::TIMING_W-1:0] key_timing [KEYFRAMES],
  input  logic [kei_pkg::COLOUR_W-1:0] key_colour [KEYFRAMES],
  output logic                         out_valid,
  output kei_pkg::kei_vals_t           out_vals
);
  import kei_pkg::*;

  kei_vals_t                base;
  kei_vals_t                other;
  logic signed [PROD_W-1:0] prod_nxt [NUM_VALS];
  logic signed [PROD_W-1:0] prod_r   [NUM_VALS];
  kei_vals_t                base_r;
  logic                     mul_vld_r;
  kei_vals_t                out_vals_nxt;
  kei_vals_t                out_vals_r;
  logic                     out_valid_r;

  // Pick the keyframe and its successor; the last one pairs with itself
  always_comb begin
    int kn;
    kn    = 0;
    base  = '0;
    other = '0;
    for (int k = 0; k < KEYFRAMES; k++) begin
      kn = (k + 1 < KEYFRAMES) ? k + 1 : k;
      if (in_frac.sel.idx == IDX_W'(k)) begin
        base  = kei_vals(key_timing[k], key_colour[k]);
        other = kei_vals(key_timing[kn], key_colour[kn]);
      end
    end
    if (in_frac.sel.empty) begin
      base = '0;
    end
    if (in_frac.sel.past) begin
      base[LANE_ALPHA] = '0;
    end
  end

  // v = x_i + (x_j - x_i) * f / 2^16, floored
  always_comb begin
    logic signed [VAL_W:0] diff;
    diff = '0;
    for (int l = 0; l < NUM_VALS; l++) begin
      diff        = $signed({1'b0, other[l]}) - $signed({1'b0, base[l]});
      prod_nxt[l] = diff * $signed({1'b0, in_frac.frac});
    end
  end

  always_comb begin
    logic signed [PROD_W-1:0] sum;
    sum = '0;
    for (int l = 0; l < NUM_VALS; l++) begin
      sum             = $signed({{(PROD_W-2*VAL_W){1'b0}}, base_r[l], {VAL_W{1'b0}}})
                        + prod_r[l];
      out_vals_nxt[l] = sum[2*VAL_W-1:VAL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      mul_vld_r   <= in_valid;
      out_valid_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_r     <= base;
      prod_r     <= prod_nxt;
      out_vals_r <= out_vals_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_vals  = out_vals_r;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for keyframe_envelope_interpolator. Loads keyframe
// tables through the config port, streams ages with random idle gaps on both
// handshakes and compares every returned width and RGBA value against a
// local envelope predictor, in request order.
// ----------------------------------------------------------------------------
module tb_top;
  import kei_pkg::*;

  localparam int KEYFRAMES    = 4;
  localparam int LATENCY      = KEYFRAMES + 7;
  localparam int LIMIT_CYCLES = 800_000;
  localparam int BATCHES      = 34;
  localparam int BATCH_ITEMS  = 50;

  // Config register map: timing word and color word per keyframe
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0_TIMING, REG_KEY0_COLOR,
    REG_KEY1_TIMING, REG_KEY1_COLOR,
    REG_KEY2_TIMING, REG_KEY2_COLOR,
    REG_KEY3_TIMING, REG_KEY3_COLOR
  } key_reg_t;

  typedef struct packed {
    logic [VAL_W-1:0] ribbon_width;
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
    logic [VAL_W-1:0] alpha;
  } envelope_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VAL_W-1:0]      in_age = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VAL_W-1:0]      out_ribbon_width;
  logic [VAL_W-1:0]      out_red;
  logic [VAL_W-1:0]      out_green;
  logic [VAL_W-1:0]      out_blue;
  logic [VAL_W-1:0]      out_alpha;

  // Shadow of the keyframe table, updated as each register is written
  logic [TIMING_W-1:0] key_timing [SLOTS] = '{default: '0};
  logic [COLOUR_W-1:0] key_color  [SLOTS] = '{default: '0};

  envelope_t   envelope_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned stall_left = 0;

  keyframe_envelope_interpolator #(.KEYFRAMES(KEYFRAMES)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_age           (in_age),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ribbon_width (out_ribbon_width),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Envelope predictor
  // --------------------------------------------------------------------------

  function automatic logic [TIMING_W-1:0] timing_word(input logic en,
      input logic [15:0] width, input logic [15:0] trn, input logic [15:0] dur);
    return {en, width, trn, dur};
  endfunction

  function automatic logic [COLOUR_W-1:0] color_word(input logic [15:0] r,
      input logic [15:0] g, input logic [15:0] b, input logic [15:0] a);
    return {a, b, g, r};
  endfunction

  // Width and RGBA of one keyframe exactly as stored
  function automatic envelope_t key_values(input int k);
    envelope_t v;
    v.ribbon_width = key_timing[k][WID_LSB +: VAL_W];
    v.red          = key_color[k][0 +: VAL_W];
    v.green        = key_color[k][VAL_W +: VAL_W];
    v.blue         = key_color[k][2*VAL_W +: VAL_W];
    v.alpha        = key_color[k][3*VAL_W +: VAL_W];
    return v;
  endfunction

  // Weighted mix with a Q1.16 fraction where 65536 means all of y; truncate
  function automatic logic [VAL_W-1:0] mix_lane(input logic [VAL_W-1:0] x,
      input logic [VAL_W-1:0] y, input logic [FRAC_W-1:0] f);
    logic [33:0] acc;
    acc = 34'(x) * (34'd65536 - 34'(f)) + 34'(y) * 34'(f);
    return acc[31:16];
  endfunction

  function automatic envelope_t predict_envelope(input logic [VAL_W-1:0] age);
    envelope_t res;
    envelope_t lo;
    envelope_t hi;
    int        count;
    logic [VAL_W-1:0]  a;
    logic [VAL_W-1:0]  dur;
    logic [VAL_W-1:0]  trn;
    logic [31:0]       num;
    logic [FRAC_W-1:0] frac;
    res = '0;
    count = 0;
    // The first disabled keyframe ends the table
    while (count < KEYFRAMES && key_timing[count][EN_BIT])
      count++;
    if (count == 0)
      return res;
    a = age;
    for (int i = 0; i < count; i++) begin
      dur = key_timing[i][DUR_LSB +: VAL_W];
      trn = key_timing[i][TRN_LSB +: VAL_W];
      if (a <= dur || i == count - 1) begin
        res = key_values(i);
        // Past the last hold: keep the values, drop alpha
        if (a > dur)
          res.alpha = '0;
        return res;
      end
      a = a - dur;
      if (trn != 0 && a <= trn) begin
        num  = {a, 16'h0000};
        frac = FRAC_W'(num / trn);
        lo = key_values(i);
        hi = key_values(i + 1);
        res.ribbon_width = mix_lane(lo.ribbon_width, hi.ribbon_width, frac);
        res.red          = mix_lane(lo.red, hi.red, frac);
        res.green        = mix_lane(lo.green, hi.green, frac);
        res.blue         = mix_lane(lo.blue, hi.blue, frac);
        res.alpha        = mix_lane(lo.alpha, hi.alpha, frac);
        return res;
      end
      a = a - trn;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Traffic helpers
  // --------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap(input int unsigned pct);
    if ($urandom_range(99) >= pct)
      return 0;
    if ($urandom_range(15) == 0)
      return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  // Hold valid and the age until accepted, then log the expected envelope
  task automatic send_age(input logic [VAL_W-1:0] age);
    int unsigned gap;
    in_valid <= 1'b1;
    in_age   <= age;
    do @(posedge clk); while (!in_ready);
    envelope_q.push_back(predict_envelope(age));
    gap = idle_gap(tx_idle_pct);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (envelope_q.size() != 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Leaves cfg_we high; load_table drops it after the last write
  task automatic write_reg(input key_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx[0])
      key_color[idx[CFG_IDX_W-1:1]] = data;
    else
      key_timing[idx[CFG_IDX_W-1:1]] = data[TIMING_W-1:0];
    @(posedge clk);
  endtask

  task automatic load_table(input logic [3:0][TIMING_W-1:0] t,
                            input logic [3:0][COLOUR_W-1:0] c);
    write_reg(REG_KEY0_TIMING, CFG_DATA_W'(t[0]));
    write_reg(REG_KEY0_COLOR,  c[0]);
    write_reg(REG_KEY1_TIMING, CFG_DATA_W'(t[1]));
    write_reg(REG_KEY1_COLOR,  c[1]);
    write_reg(REG_KEY2_TIMING, CFG_DATA_W'(t[2]));
    write_reg(REG_KEY2_COLOR,  c[2]);
    write_reg(REG_KEY3_TIMING, CFG_DATA_W'(t[3]));
    write_reg(REG_KEY3_COLOR,  c[3]);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and in-order checking
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    int unsigned len;
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      len = idle_gap(rx_stall_pct);
      if (len > 0) begin
        out_ready  <= 1'b0;
        stall_left <= len - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic compare_lane(input string name, input logic [VAL_W-1:0] exp_v,
                              input logic [VAL_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    envelope_t exp_env;
    if (rst_n && out_valid && out_ready) begin
      if (envelope_q.size() == 0) begin
        $error("result returned with no request outstanding");
        error_count++;
      end else begin
        exp_env = envelope_q.pop_front();
        compare_lane("ribbon_width", exp_env.ribbon_width, out_ribbon_width);
        compare_lane("red",   exp_env.red,   out_red);
        compare_lane("green", exp_env.green, out_green);
        compare_lane("blue",  exp_env.blue,  out_blue);
        compare_lane("alpha", exp_env.alpha, out_alpha);
      end
    end
  end

  // Watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // No counted keyframe: everything reads zero, including when a later
  // keyframe is enabled behind a disabled first one
  task automatic test_empty_table();
    logic [3:0][TIMING_W-1:0] t;
    logic [3:0][COLOUR_W-1:0] c;
    send_age(16'h0000);
    send_age(16'hFFFF);
    drain();
    t[0] = timing_word(1'b0, 16'h1234, 16'h0100, 16'h0100);
    t[1] = timing_word(1'b1, 16'h4321, 16'h0200, 16'h0200);
    t[2] = timing_word(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    t[3] = timing_word(1'b1, 16'h0001, 16'h0000, 16'h0000);
    c[0] = color_word(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    c[1] = color_word(16'h1111, 16'h2222, 16'h3333, 16'h4444);
    c[2] = color_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    c[3] = color_word(16'h0001, 16'h0002, 16'h0003, 16'h0004);
    load_table(t, c);
    send_age(16'h0000);
    send_age(16'h0150);
    drain();
  endtask

  // Four keyframes: hold edges, ramp start, middle and end, a zero
  // transition that is skipped, the last transition ignored, and past the end
  task automatic test_hold_and_ramp();
    logic [3:0][TIMING_W-1:0] t;
    logic [3:0][COLOUR_W-1:0] c;
    logic [VAL_W-1:0] ages [12];
    t[0] = timing_word(1'b1, 16'h0100, 16'h0800, 16'h1000);
    t[1] = timing_word(1'b1, 16'h0300, 16'h0000, 16'h0400);
    t[2] = timing_word(1'b1, 16'h0800, 16'h2000, 16'h0200);
    t[3] = timing_word(1'b1, 16'hFFFF, 16'h1234, 16'h0100);
    c[0] = color_word(16'h8000, 16'h0000, 16'h4000, 16'h8000);
    c[1] = color_word(16'h0000, 16'h8000, 16'h2000, 16'h6000);
    c[2] = color_word(16'h1234, 16'h7FFF, 16'h0001, 16'h4000);
    c[3] = color_word(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    ages = '{16'h0000, 16'h1000, 16'h1001, 16'h1400, 16'h1800, 16'h1C00,
             16'h1C01, 16'h1E01, 16'h3E00, 16'h3F00, 16'h3F01, 16'hFFFF};
    load_table(t, c);
    foreach (ages[i])
      send_age(ages[i]);
    drain();
  endtask

  // Full-scale fields: longest hold and ramp, colors above one, a single
  // keyframe with zero hold, and a ramp that reaches exactly its end
  task automatic test_extremes();
    logic [3:0][TIMING_W-1:0] t;
    logic [3:0][COLOUR_W-1:0] c;
    t[0] = timing_word(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    t[1] = timing_word(1'b0, 16'h0000, 16'h0000, 16'h0000);
    t[2] = timing_word(1'b1, 16'h5555, 16'h0000, 16'h0000);
    t[3] = timing_word(1'b1, 16'hAAAA, 16'h0000, 16'h0000);
    c[0] = color_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    c[1] = color_word(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    c[2] = color_word(16'h5555, 16'h5555, 16'h5555, 16'h5555);
    c[3] = color_word(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA);
    load_table(t, c);
    send_age(16'hFFFF);
    send_age(16'h0000);
    drain();

    t[0] = timing_word(1'b1, 16'h0000, 16'hFFFF, 16'h0000);
    t[1] = timing_word(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    t[2] = timing_word(1'b0, 16'h0000, 16'h0000, 16'h0000);
    c[0] = color_word(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    c[1] = color_word(16'hFFFF, 16'h8000, 16'h8001, 16'hFFFF);
    load_table(t, c);
    send_age(16'h0000);
    send_age(16'h0001);
    send_age(16'h8000);
    send_age(16'hFFFF);
    drain();

    t[0] = timing_word(1'b1, 16'h8000, 16'h0400, 16'h0000);
    t[1] = timing_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    c[0] = color_word(16'h8000, 16'h4000, 16'h2000, 16'h8000);
    load_table(t, c);
    send_age(16'h0000);
    send_age(16'h0001);
    drain();
  endtask

  function automatic logic [15:0] rand_span();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(16));
      default: return 16'($urandom_range(16'h1800));
    endcase
  endfunction

  function automatic logic [15:0] rand_channel();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'h8000;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(16'h8000));
    endcase
  endfunction

  // Random tables; most ages land inside the walked span or on or next to a
  // segment boundary, the rest anywhere
  task automatic test_random_tables();
    logic [3:0][TIMING_W-1:0] t;
    logic [3:0][COLOUR_W-1:0] c;
    logic [3:0] en;
    logic [VAL_W-1:0] marks[$];
    logic [VAL_W-1:0] dur;
    logic [VAL_W-1:0] trn;
    logic [VAL_W-1:0] age;
    int unsigned acc;
    int unsigned reach;
    for (int b = 0; b < BATCHES; b++) begin
      drain();
      case (b % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 15; rx_stall_pct = 15; end
        2: begin tx_idle_pct = 50; rx_stall_pct = 10; end
        default: begin tx_idle_pct = 10; rx_stall_pct = 50; end
      endcase
      en = ($urandom_range(9) < 7) ? 4'hF : 4'($urandom);
      marks.delete();
      acc = 0;
      for (int k = 0; k < SLOTS; k++) begin
        dur = rand_span();
        trn = rand_span();
        t[k] = timing_word(en[k], 16'($urandom), trn, dur);
        c[k] = color_word(rand_channel(), rand_channel(), rand_channel(),
                          rand_channel());
        acc += 32'(dur);
        marks.push_back((acc > 16'hFFFF) ? 16'hFFFF : VAL_W'(acc));
        acc += 32'(trn);
        marks.push_back((acc > 16'hFFFF) ? 16'hFFFF : VAL_W'(acc));
      end
      reach = (acc + 64 > 16'hFFFF) ? 16'hFFFF : acc + 64;
      load_table(t, c);
      for (int n = 0; n < BATCH_ITEMS; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: age = VAL_W'($urandom_range(reach));
          4, 5:       age = marks[$urandom_range(marks.size() - 1)] +
                            VAL_W'($urandom_range(2)) - 16'd1;
          default:    age = VAL_W'($urandom);
        endcase
        send_age(age);
        // Hold the sender until the pipeline empties now and then
        if (b % 5 == 2 && n == BATCH_ITEMS / 2)
          drain();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    test_empty_table();
    test_hold_and_ramp();
    test_extremes();
    test_random_tables();
    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (error_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/kei_pkg.sv
rtl/kei_walk.sv
rtl/kei_div.sv
rtl/kei_blend.sv
rtl/keyframe_envelope_interpolator.sv
tb/tb_top.sv
